// ===== rtl/core/mwso_pkg.sv =====
// Shared types, constants and the sine quarter-table builder for the stereo oscillator.
// Used by mwso_gain and multi_waveform_stereo_oscillator_core; depends on nothing.
package mwso_pkg;

  localparam int PHASE_BITS  = 24;
  localparam int SINE_DEPTH  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_BITS   = $clog2(SINE_DEPTH);
  localparam int QUARTER    = SINE_DEPTH / 4;
  localparam int QADDR_BITS = $clog2(QUARTER + 1);
  localparam int QVAL_BITS  = SAMPLE_BITS - 1;
  localparam int WAVE_BITS  = SAMPLE_BITS + 1;
  localparam int GAIN_BITS  = 16;
  localparam int INC_BITS   = 24;
  localparam int CFG_BITS   = 24;
  localparam int IDX_W      = 3;

  localparam logic [GAIN_BITS-1:0] GainUnity = GAIN_BITS'(32768);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Divisors (2n)(2n+1) that turn each power of x into the next odd Taylor
  // term of the sine, for n from 1 to 7.
  localparam logic [7:1][7:0] TaylorDiv =
    {8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WAVEFORM   = 3'd0,
    REG_PHASE_INC  = 3'd1,
    REG_MASTER_VOL = 3'd2,
    REG_LEFT_GAIN  = 3'd3,
    REG_RIGHT_GAIN = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_MASTER,
    ST_CHANNEL
  } state_t;

  typedef logic [QUARTER:0][QVAL_BITS-1:0] qtab_t;

  // Builds the first quadrant of the sine with a truncating fixed-point Taylor
  // series in Q30, rounded to the sample's fraction bits.
  function automatic qtab_t build_qtab();
    qtab_t           tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (HalfPiQ30 * longint'(k)) / QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'(TaylorDiv[n]);
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + (longint'(1) <<< (30 - SAMPLE_BITS))) >>> (31 - SAMPLE_BITS);
      if (v > ((longint'(1) <<< (SAMPLE_BITS - 1)) - 1)) begin
        v = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      end
      tab[k] = v[QVAL_BITS-1:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/core/mwso_gain.sv =====
// Rounding Q1.15 gain multiply with saturation to the signed sample range.
// Depends on mwso_pkg for widths.
module mwso_gain (
  input  logic signed [mwso_pkg::WAVE_BITS-1:0]   a,
  input  logic        [mwso_pkg::GAIN_BITS-1:0]   g,
  output logic signed [mwso_pkg::SAMPLE_BITS-1:0] q
);

  localparam int PROD_BITS = mwso_pkg::WAVE_BITS + mwso_pkg::GAIN_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int Q_BITS    = SUM_BITS - 15;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0]  rounded;
  logic signed [Q_BITS-1:0]    shifted;

  localparam logic signed [Q_BITS-1:0] QMax =
    Q_BITS'((64'sd1 <<< (mwso_pkg::SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_BITS-1:0] QMin =
    Q_BITS'(-(64'sd1 <<< (mwso_pkg::SAMPLE_BITS - 1)));

  always_comb begin
    prod    = PROD_BITS'(a) * PROD_BITS'($signed({1'b0, g}));
    rounded = SUM_BITS'(prod) + SUM_BITS'(16384);
    // Arithmetic shift gives floor division for negative values too.
    shifted = Q_BITS'(rounded >>> 15);
    if (shifted > QMax) begin
      q = QMax[mwso_pkg::SAMPLE_BITS-1:0];
    end else if (shifted < QMin) begin
      q = QMin[mwso_pkg::SAMPLE_BITS-1:0];
    end else begin
      q = shifted[mwso_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/multi_waveform_stereo_oscillator_core.sv =====
// Top level of the stereo direct digital synthesis oscillator.
// Depends on mwso_pkg and instantiates mwso_gain three times.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   input    | in_valid / in_ready    | in_tick
//   output   | out_valid / out_ready  | out_left_sample, out_right_sample
//   config   | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Each input transaction passes through a registered read of the sine
// quarter-table ROM, the waveform shape, the master volume multiply, and the
// two channel gain multiplies, sequenced by a four-state controller.
// The next transaction is accepted as soon as the controller is back in idle,
// even while the previous result still sits in the output register.
// The final step stalls only when the output register is full and not taken.
// Reset (synchronous, active low) clears the phase to zero and loads the
// register defaults: sine, zero increment, unity volume and gains.
module multi_waveform_stereo_oscillator_core (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_tick,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [mwso_pkg::SAMPLE_BITS-1:0]   out_left_sample,
  output logic signed [mwso_pkg::SAMPLE_BITS-1:0]   out_right_sample,
  input  logic                                      cfg_we,
  input  logic        [mwso_pkg::IDX_W-1:0]         cfg_index,
  input  logic        [mwso_pkg::CFG_BITS-1:0]      cfg_wdata
);

  localparam int P  = mwso_pkg::PHASE_BITS;
  localparam int S  = mwso_pkg::SAMPLE_BITS;
  localparam int WB = mwso_pkg::WAVE_BITS;

  // The quarter-period sine ROM is filled at elaboration.
  localparam mwso_pkg::qtab_t QTab = mwso_pkg::build_qtab();

  localparam logic signed [WB-1:0] Unity    = WB'(64'sd1 <<< (S - 1));
  localparam logic        [P-1:0]  PhHalf   = P'(64'd1 << (P - 1));
  localparam logic [mwso_pkg::QADDR_BITS-1:0] QuarterAddr =
    mwso_pkg::QADDR_BITS'(mwso_pkg::QUARTER);

  // Configuration registers.
  mwso_pkg::wave_t                   waveform_r;
  logic [mwso_pkg::INC_BITS-1:0]     phase_inc_r;
  logic [mwso_pkg::GAIN_BITS-1:0]    master_vol_r;
  logic [mwso_pkg::GAIN_BITS-1:0]    left_gain_r;
  logic [mwso_pkg::GAIN_BITS-1:0]    right_gain_r;

  // Oscillator state and datapath registers.
  mwso_pkg::state_t                  state_r, state_nxt;
  logic [P-1:0]                      phase_r;
  logic                              tick_r;
  logic [mwso_pkg::QVAL_BITS-1:0]    rom_q_r;
  logic                              neg_r;
  logic signed [WB-1:0]              wave_r, wave_nxt;
  logic signed [S-1:0]               master_r;
  logic signed [S-1:0]               left_r;
  logic signed [S-1:0]               right_r;
  logic                              out_valid_r, out_valid_nxt;

  logic [mwso_pkg::IDX_BITS-1:0]     sine_idx;
  logic [1:0]                        quad;
  logic [mwso_pkg::QADDR_BITS-1:0]   rom_addr;
  logic [P-1:0]                      tri_dist;
  logic signed [S-1:0]               master_q;
  logic signed [S-1:0]               left_q;
  logic signed [S-1:0]               right_q;
  logic                              load_out;
  logic                              accept;

  assign accept = in_valid && in_ready;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r   <= mwso_pkg::WAVE_SINE;
      phase_inc_r  <= '0;
      master_vol_r <= mwso_pkg::GainUnity;
      left_gain_r  <= mwso_pkg::GainUnity;
      right_gain_r <= mwso_pkg::GainUnity;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwso_pkg::REG_WAVEFORM:   waveform_r   <= mwso_pkg::wave_t'(cfg_wdata[1:0]);
        mwso_pkg::REG_PHASE_INC:  phase_inc_r  <= cfg_wdata[mwso_pkg::INC_BITS-1:0];
        mwso_pkg::REG_MASTER_VOL: master_vol_r <= cfg_wdata[mwso_pkg::GAIN_BITS-1:0];
        mwso_pkg::REG_LEFT_GAIN:  left_gain_r  <= cfg_wdata[mwso_pkg::GAIN_BITS-1:0];
        mwso_pkg::REG_RIGHT_GAIN: right_gain_r <= cfg_wdata[mwso_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sine table addressing: the top phase bits pick a table slot, the top two
  // of those pick the quadrant. Odd quadrants read the quarter table mirrored.
  always_comb begin
    sine_idx = phase_r[P-1 -: mwso_pkg::IDX_BITS];
    quad     = sine_idx[mwso_pkg::IDX_BITS-1 -: 2];
    if (quad[0]) begin
      rom_addr = QuarterAddr
               - mwso_pkg::QADDR_BITS'(sine_idx[mwso_pkg::IDX_BITS-3:0]);
    end else begin
      rom_addr = mwso_pkg::QADDR_BITS'(sine_idx[mwso_pkg::IDX_BITS-3:0]);
    end
  end

  // The ROM is read every cycle; phase is stable from acceptance to the end
  // of the transaction, so the data is valid in the shape step.
  always_ff @(posedge clk) begin
    rom_q_r <= QTab[rom_addr];
    neg_r   <= quad[1];
  end

  // Waveform shape in signed Q1.15 with one extra bit so that +1.0 fits.
  always_comb begin
    tri_dist = phase_r[P-1] ? {1'b0, phase_r[P-2:0]} : (PhHalf - phase_r);
    case (waveform_r)
      mwso_pkg::WAVE_SINE: begin
        wave_nxt = neg_r ? -$signed(WB'({2'b00, rom_q_r}))
                         :  $signed(WB'({2'b00, rom_q_r}));
      end
      mwso_pkg::WAVE_SQUARE: begin
        wave_nxt = (phase_r > PhHalf) ? Unity : -Unity;
      end
      mwso_pkg::WAVE_SAW: begin
        wave_nxt = $signed({1'b0, phase_r[P-1 -: S]}) - Unity;
      end
      default: begin
        // The distance from half a cycle spans at most half of the phase range,
        // so its top S+1 bits scale it by four and reach two at the ends.
        wave_nxt = WB'($signed({1'b0, tri_dist[P-1 -: S+1]}) - (WB+1)'(Unity));
      end
    endcase
  end

  mwso_gain u_master (
    .a (wave_r),
    .g (master_vol_r),
    .q (master_q)
  );

  mwso_gain u_left (
    .a (WB'(master_r)),
    .g (left_gain_r),
    .q (left_q)
  );

  mwso_gain u_right (
    .a (WB'(master_r)),
    .g (right_gain_r),
    .q (right_q)
  );

  // Sequencer: accept, shape, master volume, channel gains.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      mwso_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = mwso_pkg::ST_SHAPE;
        end
      end
      mwso_pkg::ST_SHAPE: begin
        state_nxt = mwso_pkg::ST_MASTER;
      end
      mwso_pkg::ST_MASTER: begin
        state_nxt = mwso_pkg::ST_CHANNEL;
      end
      mwso_pkg::ST_CHANNEL: begin
        // Wait here only while an earlier result has not been taken.
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = mwso_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwso_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwso_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // The phase advances after the sample has been formed, if the tick was set.
      if (load_out && tick_r) begin
        phase_r <= phase_r + phase_inc_r[P-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r <= in_tick;
    end
    if (state_r == mwso_pkg::ST_SHAPE) begin
      wave_r <= wave_nxt;
    end
    if (state_r == mwso_pkg::ST_MASTER) begin
      master_r <= master_q;
    end
    if (load_out) begin
      left_r  <= left_q;
      right_r <= right_q;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

endmodule
